// ===== sv/mdst_pkg.sv =====
// Shared types and constants for the magazine depot slot table.
`timescale 1ns / 1ps

package mdst_pkg;

  // Fixed field widths of the stream payloads
  localparam int OP_W       = 2;
  localparam int CLS_W      = 4;
  localparam int MAG_W      = 48;
  localparam int CNT_W      = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT,
    ST_SCAN,
    ST_FOUT
  } mdst_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_item;
    logic do_push;
    logic do_pop;
    logic load_empty;
    logic flush_start;
    logic scan_take;
    logic scan_adv;
  } mdst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            live_any;
    logic            cur_hit;
    logic            out_last;
  } mdst_stat_t;

endpackage

// ===== sv/mdst_dp.sv =====
// Datapath: slot storage, occupancy flags, flush walker and result register.
`timescale 1ns / 1ps

module mdst_dp #(
  parameter int SLOTS_PER_CLASS = 4,
  parameter int MAX_CLASSES     = 8,
  parameter int HANDLE_WIDTH    = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mdst_pkg::CNT_W-1:0]    cfg_data,
  input  logic [mdst_pkg::OP_W-1:0]     in_op,
  input  logic [mdst_pkg::CLS_W-1:0]    in_cls,
  input  logic [mdst_pkg::MAG_W-1:0]    in_mag,
  input  mdst_pkg::mdst_cmd_t           cmd,
  output mdst_pkg::mdst_stat_t          stat,
  output logic                          out_ok,
  output logic [mdst_pkg::MAG_W-1:0]    out_handle,
  output logic [mdst_pkg::CLS_W-1:0]    out_cls,
  output logic                          out_last
);
  import mdst_pkg::*;

  localparam int DEPTH  = MAX_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int ROW_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  // Configuration and latched item
  logic [CNT_W-1:0]        class_count;
  logic [OP_W-1:0]         item_op;
  logic [CLS_W-1:0]        item_cls;
  logic [HANDLE_WIDTH-1:0] item_mag;

  // Storage
  logic [HANDLE_WIDTH-1:0] mem [DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_data;
  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        live;
  logic [DEPTH-1:0]        fmask;
  logic [DEPTH-1:0]        sp_onehot;

  // Flush walker
  logic [ADDR_W-1:0]       sp;
  logic [ROW_W-1:0]        scls;
  logic [SLOT_W-1:0]       sslot;

  // Result register
  logic                    out_sel;

  // Row decode
  logic [CNT_W-1:0]           n_live;
  logic                       cls_ok;
  logic [ROW_W-1:0]           item_row;
  logic [ADDR_W-1:0]          row_base;
  logic [SLOTS_PER_CLASS-1:0] row_occ;
  logic                       has_free;
  logic                       has_used;
  logic [SLOT_W-1:0]          free_slot;
  logic [SLOT_W-1:0]          used_slot;
  logic                       push_ok;
  logic                       pop_ok;
  logic [ADDR_W-1:0]          push_addr;
  logic [ADDR_W-1:0]          pop_addr;
  logic [ADDR_W-1:0]          raddr;
  logic                       mem_we;
  logic                       mem_re;

  // Saturate the class count
  assign n_live   = (class_count > CNT_W'(MAX_CLASSES)) ? CNT_W'(MAX_CLASSES) : class_count;
  assign cls_ok   = item_cls < n_live;
  assign item_row = item_cls[ROW_W-1:0];
  assign row_base = ADDR_W'(item_row) * ADDR_W'(SLOTS_PER_CLASS);

  // Gather the addressed row and find its lowest free and lowest used slot
  always_comb begin
    logic [ADDR_W-1:0] idx;
    has_free  = 1'b0;
    has_used  = 1'b0;
    free_slot = '0;
    used_slot = '0;
    for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
      idx        = row_base + ADDR_W'(i);
      row_occ[i] = cls_ok && occ[idx];
    end
    for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
      if (!row_occ[i]) begin
        has_free  = 1'b1;
        free_slot = SLOT_W'(i);
      end
      if (row_occ[i]) begin
        has_used  = 1'b1;
        used_slot = SLOT_W'(i);
      end
    end
  end

  assign push_ok   = cls_ok && has_free;
  assign pop_ok    = cls_ok && has_used;
  assign push_addr = row_base + ADDR_W'(free_slot);
  assign pop_addr  = row_base + ADDR_W'(used_slot);

  // Occupied slots of classes in use
  for (genvar j = 0; j < DEPTH; j++) begin : g_live
    localparam int JC = j / SLOTS_PER_CLASS;
    assign live[j] = occ[j] && (CNT_W'(JC) < n_live);
  end

  assign sp_onehot = DEPTH'(1) << sp;

  // Memory ports
  assign mem_we = cmd.do_push && push_ok && (item_mag != '0);
  assign mem_re = (cmd.do_pop && pop_ok) || cmd.scan_take;
  assign raddr  = cmd.scan_take ? sp : pop_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[push_addr] <= item_mag;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  // Control state: register, occupancy flags, flush mask
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= '0;
      occ         <= '0;
      fmask       <= '0;
    end else begin
      if (cfg_we) begin
        class_count <= cfg_data;
      end
      if (mem_we) begin
        occ[push_addr] <= 1'b1;
      end
      if (cmd.do_pop && pop_ok) begin
        occ[pop_addr] <= 1'b0;
      end
      if (cmd.flush_start) begin
        fmask <= live;
      end
      if (cmd.scan_take) begin
        occ[sp]   <= 1'b0;
        fmask[sp] <= 1'b0;
      end
    end
  end

  // Item capture, walker pointers and result register
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_op  <= in_op;
      item_cls <= in_cls;
      item_mag <= HANDLE_WIDTH'(in_mag);
    end
    if (cmd.flush_start) begin
      sp    <= '0;
      scls  <= '0;
      sslot <= '0;
    end else if (cmd.scan_adv) begin
      sp <= sp + 1'b1;
      if (sslot == SLOT_W'(SLOTS_PER_CLASS - 1)) begin
        sslot <= '0;
        scls  <= scls + 1'b1;
      end else begin
        sslot <= sslot + 1'b1;
      end
    end
    if (cmd.do_push) begin
      out_ok   <= push_ok;
      out_sel  <= 1'b0;
      out_cls  <= item_cls;
      out_last <= 1'b1;
    end else if (cmd.do_pop) begin
      out_ok   <= pop_ok;
      out_sel  <= pop_ok;
      out_cls  <= item_cls;
      out_last <= 1'b1;
    end else if (cmd.load_empty) begin
      out_ok   <= 1'b0;
      out_sel  <= 1'b0;
      out_cls  <= '0;
      out_last <= 1'b1;
    end else if (cmd.scan_take) begin
      out_ok   <= 1'b1;
      out_sel  <= 1'b1;
      out_cls  <= CLS_W'(scls);
      out_last <= (fmask & ~sp_onehot) == '0;
    end
  end

  // Handle comes from the read register only when a slot was taken
  assign out_handle = out_sel ? MAG_W'(rd_data) : '0;

  assign stat.op       = item_op;
  assign stat.live_any = live != '0;
  assign stat.cur_hit  = fmask[sp];
  assign stat.out_last = out_last;

  // Flush mask never names a slot that is already empty
  a_fmask_in_occ: assert property (@(posedge clk) disable iff (rst)
    (fmask & ~occ) == '0)
    else $error("flush mask covers an empty slot");

  // A stored non-null handle marks its slot occupied
  a_push_sets: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> occ[$past(push_addr)])
    else $error("push did not mark slot occupied");

  // A slot taken by flush is empty afterward
  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_take |=> !occ[$past(sp)] && !fmask[$past(sp)])
    else $error("flushed slot still occupied");

endmodule

// ===== sv/mdst_ctrl.sv =====
// Controller: sequences push, pop and flush and drives the stream handshakes.
`timescale 1ns / 1ps

module mdst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  mdst_pkg::mdst_stat_t  stat,
  output mdst_pkg::mdst_cmd_t   cmd
);
  import mdst_pkg::*;

  mdst_state_t state;
  mdst_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.op)
          OP_PUSH: begin
            cmd.do_push = 1'b1;
            state_next  = ST_OUT;
          end
          OP_POP: begin
            cmd.do_pop = 1'b1;
            state_next = ST_OUT;
          end
          OP_FLUSH: begin
            if (stat.live_any) begin
              cmd.flush_start = 1'b1;
              state_next      = ST_SCAN;
            end else begin
              cmd.load_empty = 1'b1;
              state_next     = ST_OUT;
            end
          end
          default: begin
            cmd.load_empty = 1'b1;
            state_next     = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        // Overlap the result transfer with the next item transfer
        m_tvalid = 1'b1;
        s_tready = m_tready;
        if (m_tready) begin
          if (s_tvalid) begin
            cmd.take_item = 1'b1;
            state_next    = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (stat.cur_hit) begin
          cmd.scan_take = 1'b1;
          state_next    = ST_FOUT;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_FOUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = stat.out_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Input is taken only when no result is left behind
  a_no_stranded: assert property (@(posedge clk) disable iff (rst)
    (s_tready && m_tvalid) |-> m_tready)
    else $error("input taken while result stalled");

  // A freshly taken item never shows a result in the next cycle
  a_fresh_item: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> !m_tvalid)
    else $error("result shown before item executed");

  // Flush walker only advances while no result is pending
  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_adv || cmd.scan_take) |-> !m_tvalid && !s_tready)
    else $error("flush walk overlaps a handshake");

endmodule

// ===== sv/magazine_depot_slot_table_core.sv =====
// Top level of the magazine depot slot table.
//
//   channel   direction  handshake           payload
//   cfg       in         cfg_valid/ready     cfg_data[3:0] class_count
//   s         in         s_tvalid/tready     tuser operation, tdata class_index, magazine
//   m         out        m_tvalid/tready     tuser ok, tdata handle_out, class_out; tlast
//
// Push and pop take the item in the transfer cycle, then the execute state reads the class
// row of occupancy flags and writes or reads the slot memory; the result register is
// handed off in the same cycle as the next input transfer. Flush with no live handle
// found goes to the result directly, like a pop. Otherwise the walker starts at slot 0,
// steps past each slot not in the flush mask, and for each handle takes it and transfers
// the result, stepping past it unless it was the last; the next transfer waits in idle.
// Reset clears the occupancy flags at once; no clearing pass is needed.
// A stalled result holds the block; cfg_ready is always high.
`timescale 1ns / 1ps

module magazine_depot_slot_table_core #(
  parameter int SLOTS_PER_CLASS = 4,
  parameter int MAX_CLASSES     = 8,
  parameter int HANDLE_WIDTH    = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mdst_pkg::CNT_W-1:0]          cfg_data,   // class_count
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mdst_pkg::IN_DATA_W-1:0]      s_tdata,    // class_index[3:0], magazine[51:4]
  input  logic [mdst_pkg::OP_W-1:0]           s_tuser,    // operation[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mdst_pkg::OUT_DATA_W-1:0]     m_tdata,    // handle_out[47:0], class_out[51:48]
  output logic                                m_tuser,    // ok
  output logic                                m_tlast
);
  import mdst_pkg::*;

  mdst_cmd_t         cmd;
  mdst_stat_t        stat;
  logic              out_ok;
  logic [MAG_W-1:0]  out_handle;
  logic [CLS_W-1:0]  out_cls;
  logic              out_last;

  assign cfg_ready = 1'b1;

  mdst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdst_dp #(
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .MAX_CLASSES     (MAX_CLASSES),
    .HANDLE_WIDTH    (HANDLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .in_op      (s_tuser),
    .in_cls     (s_tdata[CLS_W-1:0]),
    .in_mag     (s_tdata[CLS_W+MAG_W-1:CLS_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ok     (out_ok),
    .out_handle (out_handle),
    .out_cls    (out_cls),
    .out_last   (out_last)
  );

  // Pack the result
  assign m_tdata = {{(OUT_DATA_W - MAG_W - CLS_W){1'b0}}, out_cls, out_handle};
  assign m_tuser = out_ok;
  assign m_tlast = out_last;

endmodule
